@@ hdl/tat_pkg.sv @@
// ----------------------------------------------------------------------------
// tat_pkg
// Shared types and constants for the tick-driven alarm table.
// ----------------------------------------------------------------------------
package tat_pkg;

  // Table geometry.
  localparam int ALARM_SLOTS = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Tick counter and deadline width.
  localparam int TICK_W = 64;

  // Division of a 32-bit delay by ten: multiply by ceil(2^35 / 10) and keep
  // the bits from 35 up. This is exact for every 32-bit dividend.
  localparam logic [31:0] DIV_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV_SHIFT = 35;
  localparam int          QUOT_W    = 64 - DIV_SHIFT;

  // Input opcodes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [1:0] KIND_FIRED    = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [15:0]       process_id;
    logic signed [7:0] message_prefix;
    logic [31:0]       delay_time;
  } req_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [15:0]       fired_pid;
    logic signed [7:0] fired_prefix;
    logic              last;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the accepted request word
    logic quot;     // register delay / 10
    logic add;      // store the alarm and emit the add result
    logic tick;     // advance the tick counter and restart the scan
    logic step;     // examine one slot, fire it when due
    logic flush;    // emit the held firing as the final result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_add;
    logic hit;
    logic pend_valid;
    logic out_free;
    logic scan_end;
  } status_t;

endpackage

@@ hdl/tat_ctrl.sv @@
// ----------------------------------------------------------------------------
// tat_ctrl
// Sequencer for the alarm table: add path and slot-by-slot tick scan.
// ----------------------------------------------------------------------------
module tat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  tat_pkg::status_t status,
  output tat_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_ADD   = 6'b000100,
    S_TICK  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DIV;
        end
      end
      S_DIV: begin
        // The captured opcode decides the path.
        if (status.is_add) begin
          cmd.quot   = 1'b1;
          state_next = S_ADD;
        end else begin
          state_next = S_TICK;
        end
      end
      S_ADD: begin
        if (status.out_free) begin
          cmd.add    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        cmd.tick   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        // A hit pushes the held firing out, which needs room at the output.
        if (!(status.hit && status.pend_valid && !status.out_free)) begin
          cmd.step = 1'b1;
          if (status.scan_end) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/tat_datapath.sv @@
// ----------------------------------------------------------------------------
// tat_datapath
// Slot table, tick counter, delay divider and output register.
// ----------------------------------------------------------------------------
module tat_datapath (
  input  logic             clk,
  input  logic             rst,
  input  tat_pkg::req_t    req,
  input  tat_pkg::cmd_t    cmd,
  output tat_pkg::status_t status,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output tat_pkg::rsp_t    rsp
);

  // Captured request and the registered quotient.
  tat_pkg::req_t                     req_reg;
  logic [tat_pkg::QUOT_W-1:0]        quot;
  logic [63:0]                       prod;

  // Tick counter and scan control.
  logic [tat_pkg::TICK_W-1:0]        tick_count;
  logic [tat_pkg::SLOT_W-1:0]        scan_idx;
  logic [tat_pkg::CNT_W-1:0]         fired_cnt;

  // Slot table.
  logic [tat_pkg::ALARM_SLOTS-1:0]   slot_valid;
  logic [15:0]                       slot_pid      [tat_pkg::ALARM_SLOTS];
  logic [7:0]                        slot_prefix   [tat_pkg::ALARM_SLOTS];
  logic [tat_pkg::TICK_W-1:0]        slot_deadline [tat_pkg::ALARM_SLOTS];

  // Firing held back until it is known whether it is the last one.
  logic                              pend_valid;
  logic [15:0]                       pend_pid;
  logic [7:0]                        pend_prefix;

  // Lowest free slot.
  logic                              free_any;
  logic [tat_pkg::SLOT_W-1:0]        free_idx;

  logic                              hit;
  logic                              out_free;
  logic                              emit;
  tat_pkg::rsp_t                     emit_word;

  assign prod = 64'(req_reg.delay_time) * 64'(tat_pkg::DIV_RECIP);

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = tat_pkg::ALARM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_any = 1'b1;
        free_idx = tat_pkg::SLOT_W'(i);
      end
    end
  end

  assign hit = slot_valid[scan_idx] && (tick_count >= slot_deadline[scan_idx]) &&
               (fired_cnt < tat_pkg::CNT_W'(tat_pkg::MAX_RESULTS));

  assign out_free = !rsp_valid || !rsp_stall;

  // Output word selection.
  always_comb begin
    emit      = 1'b0;
    emit_word = '0;
    if (cmd.add) begin
      emit                     = 1'b1;
      emit_word.result_kind    = free_any ? tat_pkg::KIND_ADD_OK : tat_pkg::KIND_ADD_FULL;
      emit_word.fired_pid      = req_reg.process_id;
      emit_word.fired_prefix   = req_reg.message_prefix;
      emit_word.last           = 1'b1;
    end else if ((cmd.step && hit && pend_valid) || cmd.flush) begin
      emit                     = 1'b1;
      emit_word.result_kind    = tat_pkg::KIND_FIRED;
      emit_word.fired_pid      = pend_pid;
      emit_word.fired_prefix   = pend_prefix;
      emit_word.last           = cmd.flush;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      slot_valid <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
      scan_idx   <= '0;
      fired_cnt  <= '0;
    end else begin
      if (cmd.add && free_any) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (cmd.tick) begin
        tick_count <= tick_count + 1'b1;
        scan_idx   <= '0;
        fired_cnt  <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.step) begin
        scan_idx <= scan_idx + 1'b1;
        if (hit) begin
          slot_valid[scan_idx] <= 1'b0;
          pend_valid           <= 1'b1;
          fired_cnt            <= fired_cnt + 1'b1;
        end
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_reg <= req;
    end
    if (cmd.quot) begin
      quot <= prod[63:tat_pkg::DIV_SHIFT];
    end
    if (cmd.add && free_any) begin
      slot_pid[free_idx]      <= req_reg.process_id;
      slot_prefix[free_idx]   <= req_reg.message_prefix;
      slot_deadline[free_idx] <= tick_count + tat_pkg::TICK_W'(quot);
    end
    if (cmd.step && hit) begin
      pend_pid    <= slot_pid[scan_idx];
      pend_prefix <= slot_prefix[scan_idx];
    end
    if (emit) begin
      rsp <= emit_word;
    end
  end

  assign status.is_add     = (req_reg.opcode == tat_pkg::OP_ADD);
  assign status.hit        = hit;
  assign status.pend_valid = pend_valid;
  assign status.out_free   = out_free;
  assign status.scan_end   = (scan_idx == tat_pkg::SLOT_W'(tat_pkg::ALARM_SLOTS - 1));

endmodule

@@ hdl/tick_alarm_table_top.sv @@
// ----------------------------------------------------------------------------
// tick_alarm_table_top
// Tick-driven alarm table with a 64-bit tick counter and a fixed slot table.
// ----------------------------------------------------------------------------
// Usage notes.
// The request channel (req_valid, req_stall, req) carries one word per item.
// A word with opcode add stores a process id, a prefix byte and a deadline of
// the current tick count plus delay_time / 10 in the lowest free slot, and
// always answers with exactly one response word (accepted or table full).
// A word with opcode tick advances the tick counter by one, then walks the
// slots in ascending order and fires every stored alarm that is due. Each
// firing is one response word, the final one carrying last; a tick that
// fires nothing produces no response.
// Steps: an add passes through capture, divide by reciprocal multiply and
// slot write, the slot write waiting for room at the output. A tick passes
// through capture, decode, counter increment, a scan that examines the slots
// one at a time and may pause for the output, and a final flush. Only one
// request is in work at a time, so req_stall is high from the cycle after
// acceptance until the item is done.
// The response channel (rsp_valid, rsp_stall, rsp) is driven from a single
// output register. While the receiver stalls, the word holds, and the scan
// pauses only when a new firing has to be pushed out behind it.
// Reset clears the tick counter, all slot valid bits and both channels.
// ----------------------------------------------------------------------------
module tick_alarm_table_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tat_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tat_pkg::rsp_t rsp
);

  // Command and status between the sequencer and the datapath.
  tat_pkg::cmd_t    cmd;
  tat_pkg::status_t status;

  // The sequencer owns the request handshake and the scan ordering.
  tat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath owns the table, the tick counter and the response register.
  tat_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

@@ tb/tb_tick_alarm_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tick_alarm_table_top
// Self-checking bench for the tick-driven alarm table. A driver feeds add and
// tick words from a backlog. A behavioral copy of the slot table and the tick
// counter predicts every response word. A monitor compares each response word
// field by field with the oldest predicted one, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_tick_alarm_table_top;

  // Delay units per tick: an alarm waits delay_time / DELAY_UNITS ticks.
  localparam logic [31:0] DELAY_UNITS = 32'd10;
  // Cycles to let a tick scan finish after the last response word. A quiet
  // tick gives no word, yet it keeps the block busy through its whole scan.
  localparam int SCAN_SETTLE = tat_pkg::ALARM_SLOTS + 8;
  // Cycles without any accepted word before the run is declared hung.
  localparam int HANG_LIMIT = 5000;
  localparam int WORDS_PER_PHASE = 72;
  localparam int PHASES = 4;
  // Sender idle and receiver stall percentages of each random phase.
  localparam int unsigned SEND_PCT [PHASES] = '{0, 76, 0, 20};
  localparam int unsigned RECV_PCT [PHASES] = '{0, 0, 76, 20};

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  tat_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  tat_pkg::rsp_t rsp;

  // Words waiting to be driven, and response words still to arrive.
  tat_pkg::req_t req_backlog[$];
  tat_pkg::rsp_t awaited_rsp[$];

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  // Behavioral copy of the block's state.
  logic [tat_pkg::TICK_W-1:0] ticks_seen;
  logic                       slot_armed [tat_pkg::ALARM_SLOTS];
  logic [15:0]                slot_owner [tat_pkg::ALARM_SLOTS];
  logic signed [7:0]          slot_tag   [tat_pkg::ALARM_SLOTS];
  logic [tat_pkg::TICK_W-1:0] slot_due   [tat_pkg::ALARM_SLOTS];

  tick_alarm_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the response words of one accepted request word and queues
  // them. An add always answers once; a tick answers once per fired alarm,
  // lowest slot first, at most MAX_RESULTS times, and a quiet tick not at all.
  function automatic void predict_alarm_words(tat_pkg::req_t w);
    tat_pkg::rsp_t fired[$];
    tat_pkg::rsp_t r;
    logic placed;
    placed = 1'b0;
    if (w.opcode == tat_pkg::OP_ADD) begin
      for (int i = 0; i < tat_pkg::ALARM_SLOTS; i++) begin
        if (!placed && !slot_armed[i]) begin
          placed = 1'b1;
          slot_armed[i] = 1'b1;
          slot_owner[i] = w.process_id;
          slot_tag[i] = w.message_prefix;
          slot_due[i] = ticks_seen + tat_pkg::TICK_W'(w.delay_time / DELAY_UNITS);
        end
      end
      r.result_kind = placed ? tat_pkg::KIND_ADD_OK : tat_pkg::KIND_ADD_FULL;
      r.fired_pid = w.process_id;
      r.fired_prefix = w.message_prefix;
      r.last = 1'b1;
      awaited_rsp.push_back(r);
    end else begin
      ticks_seen = ticks_seen + 1'b1;
      for (int i = 0; i < tat_pkg::ALARM_SLOTS; i++) begin
        if (fired.size() < tat_pkg::MAX_RESULTS && slot_armed[i] &&
            ticks_seen >= slot_due[i]) begin
          slot_armed[i] = 1'b0;
          r.result_kind = tat_pkg::KIND_FIRED;
          r.fired_pid = slot_owner[i];
          r.fired_prefix = slot_tag[i];
          r.last = 1'b0;
          fired.push_back(r);
        end
      end
      if (fired.size() != 0) begin
        fired[fired.size() - 1].last = 1'b1;
      end
      foreach (fired[k]) begin
        awaited_rsp.push_back(fired[k]);
      end
    end
  endfunction

  function automatic tat_pkg::req_t make_add(logic [15:0] pid, logic signed [7:0] tag,
                                             logic [31:0] delay);
    tat_pkg::req_t w;
    w.opcode = tat_pkg::OP_ADD;
    w.process_id = pid;
    w.message_prefix = tag;
    w.delay_time = delay;
    return w;
  endfunction

  // The other fields of a tick word are ignored by the block, so they carry
  // random junk.
  function automatic tat_pkg::req_t make_tick();
    tat_pkg::req_t w;
    w.opcode = tat_pkg::OP_TICK;
    w.process_id = 16'($urandom);
    w.message_prefix = 8'($urandom);
    w.delay_time = $urandom;
    return w;
  endfunction

  // Random traffic keeps most delays within a few ticks so that alarms fire
  // and slots recycle; the add share is high enough that the table fills now
  // and then. A rare full-range delay parks an alarm for good.
  function automatic tat_pkg::req_t random_word();
    logic [31:0] delay;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      return make_tick();
    end
    pick = $urandom_range(99);
    if (pick < 3) begin
      delay = $urandom;
    end else if (pick < 25) begin
      delay = $urandom_range(0, 19);
    end else begin
      delay = $urandom_range(0, 159);
    end
    return make_add(16'($urandom), 8'($urandom), delay);
  endfunction

  // Driver: a word stays on the bus until it is taken; only then is the next
  // one from the backlog offered, or the bus left idle for a cycle.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_alarm_words(req);
      end
      if (!req_valid || !req_stall) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= req_backlog.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every response word taken is matched against the oldest
  // prediction. The stall for the next cycle is drawn fresh each cycle.
  always @(posedge clk) begin
    tat_pkg::rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          fail_count++;
          $display("%0t: expected none, actual kind=%0d pid=%h prefix=%0d last=%b",
                   $time, rsp.result_kind, rsp.fired_pid, rsp.fired_prefix, rsp.last);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.result_kind !== want.result_kind || rsp.fired_pid !== want.fired_pid ||
              rsp.fired_prefix !== want.fired_prefix || rsp.last !== want.last) begin
            fail_count++;
            $display("%0t: expected %0d %h %0d %b, actual %0d %h %0d %b",
                     $time, want.result_kind, want.fired_pid, want.fired_prefix,
                     want.last, rsp.result_kind, rsp.fired_pid, rsp.fired_prefix,
                     rsp.last);
          end
        end
      end
    end
  end

  // Hang detector: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= HANG_LIMIT);
    $display("tick_alarm_table_top: mismatch");
    $finish;
  end

  // Holds off the sender until every word is taken, every response word has
  // come, and a possible quiet tick has finished its scan.
  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_valid || awaited_rsp.size() != 0) begin
      @(negedge clk);
    end
    repeat (SCAN_SETTLE) @(negedge clk);
  endtask

  // Stimulus. Everything the bench changes after the reset release happens at the
  // falling edge, away from the edge at which the driver and monitor sample.
  initial begin
    ticks_seen = '0;
    foreach (slot_armed[i]) begin
      slot_armed[i] = 1'b0;
      slot_owner[i] = '0;
      slot_tag[i] = '0;
      slot_due[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, no idling. A quiet tick on the empty table comes first.
    req_backlog.push_back(make_tick());
    // Extreme pid and prefix values. A delay of zero is already due; a delay
    // of nine truncates to zero ticks, ten to one tick. All fire on the tick.
    req_backlog.push_back(make_add(16'h0000, -8'sd128, 32'd0));
    req_backlog.push_back(make_add(16'hFFFF, 8'sd127, 32'd9));
    req_backlog.push_back(make_add(16'h1234, 8'sd0, 32'd10));
    req_backlog.push_back(make_tick());
    // The largest delay parks an alarm that never comes due in this run.
    req_backlog.push_back(make_add(16'hA5A5, -8'sd1, 32'hFFFF_FFFF));
    // Fill the rest of the table, then one add more is refused.
    repeat (tat_pkg::ALARM_SLOTS - 1) begin
      req_backlog.push_back(make_add(16'($urandom), 8'($urandom), 32'd20));
    end
    req_backlog.push_back(make_add(16'h5A5A, 8'sh55, 32'd0));
    // One quiet tick, then a tick that fires every filled slot but the parked one.
    req_backlog.push_back(make_tick());
    req_backlog.push_back(make_tick());

    // Random phases; the sender holds off between them until all is drained.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      send_idle_pct = SEND_PCT[ph];
      recv_stall_pct = RECV_PCT[ph];
      repeat (WORDS_PER_PHASE) req_backlog.push_back(random_word());
    end
    wait_drained();

    if (awaited_rsp.size() != 0) begin
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tick_alarm_table_top: match");
    end else begin
      $display("tick_alarm_table_top: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tat_pkg.sv
hdl/tat_ctrl.sv
hdl/tat_datapath.sv
hdl/tick_alarm_table_top.sv
tb/tb_tick_alarm_table_top.sv
